>>> hw/rtl/ssms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared types and codes for the sorted store with lower-median select.
// ----------------------------------------------------------------------------
package ssms_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic STATUS_MEDIAN = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] median_value;
        logic                     status;
    } t_result;

    // broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // position of one cell relative to the fill level and the median
    typedef struct packed {
        logic occupied;
        logic past_median;
        logic at_median;
    } t_cell_pos;

endpackage

>>> hw/rtl/ssms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_cell
// One entry of the sorted chain: compare, hold or shift toward a neighbor.
// ----------------------------------------------------------------------------
module ssms_cell
    import ssms_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  t_cell_pos                i_pos,
    input  logic                     i_left_less,
    input  logic signed [DATA_W-1:0] i_left_value,
    input  logic signed [DATA_W-1:0] i_right_value,
    output logic                     o_less,
    output logic signed [DATA_W-1:0] o_value,
    output logic signed [DATA_W-1:0] o_sel_value
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    assign o_less      = i_pos.occupied && (r_value < i_ctl.value);
    assign o_value     = r_value;
    assign o_sel_value = i_pos.at_median ? r_value : '0;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (!o_less) begin
                n_value = i_left_less ? i_ctl.value : i_left_value;
            end
        end else if (i_ctl.rem) begin
            if (i_pos.past_median) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> hw/rtl/sorted_store_median_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_store_median_select
// Sorted multiset of signed values with insert, lower-median remove and query.
// ----------------------------------------------------------------------------
// One transaction is taken in every cycle (busy stays low): a row of CAPACITY
// cells compares and shifts all entries in parallel, so each insert, remove
// or query finishes in the cycle it is accepted. A query on a non-empty store
// and an insert into a full store each give one result, strobed on
// o_result_valid for one cycle, in the cycle after acceptance. The receiver
// cannot stall, so the result must be captured on that cycle.
// ----------------------------------------------------------------------------
module sorted_store_median_select
    import ssms_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_result_valid,
    output t_result o_result
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] med_pos;
    logic             accept;
    logic             empty;
    logic             full;
    t_cell_ctl        ctl;
    logic             r_result_valid;
    logic             n_result_valid;
    t_result          r_result;
    t_result          n_result;
    logic signed [DATA_W-1:0] median;

    logic                     less   [CAPACITY];
    logic signed [DATA_W-1:0] values [CAPACITY];
    logic signed [DATA_W-1:0] sel    [CAPACITY];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign empty   = (r_count == '0);
    assign full    = (r_count >= CNT_W'(CAPACITY));
    assign med_pos = (r_count - CNT_W'(1)) >> 1;

    assign ctl.ins   = accept && (i_item.op == OP_INSERT) && !full;
    assign ctl.rem   = accept && (i_item.op == OP_REMOVE) && !empty;
    assign ctl.value = i_item.value;

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            t_cell_pos                pos;
            logic                     left_less;
            logic signed [DATA_W-1:0] left_value;
            logic signed [DATA_W-1:0] right_value;

            assign pos.occupied    = (CNT_W'(g) < r_count);
            assign pos.past_median = (CNT_W'(g) >= med_pos);
            assign pos.at_median   = (CNT_W'(g) == med_pos);

            if (g == 0) begin : g_first
                assign left_less  = 1'b1;
                assign left_value = '0;
            end else begin : g_inner
                assign left_less  = less[g-1];
                assign left_value = values[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign right_value = values[g];
            end else begin : g_body
                assign right_value = values[g+1];
            end

            ssms_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_pos        (pos),
                .i_left_less  (left_less),
                .i_left_value (left_value),
                .i_right_value(right_value),
                .o_less       (less[g]),
                .o_value      (values[g]),
                .o_sel_value  (sel[g])
            );
        end
    endgenerate

    always_comb begin
        median = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            median = median | sel[k];
        end
    end

    always_comb begin
        n_count        = r_count;
        n_result_valid = 1'b0;
        n_result       = r_result;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
        if (accept && (i_item.op == OP_INSERT) && full) begin
            n_result_valid        = 1'b1;
            n_result.median_value = '0;
            n_result.status       = STATUS_FULL;
        end else if (accept && (i_item.op == OP_QUERY) && !empty) begin
            n_result_valid        = 1'b1;
            n_result.median_value = median;
            n_result.status       = STATUS_MEDIAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_count        <= n_count;
            r_result_valid <= n_result_valid;
        end
        r_result <= n_result;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule
